// ===== sv/bbrc_pkg.sv =====
// Shared types and constants for the bracket balance range checker.
// Holds tree sizing, value types, opcodes, walk ids and the control/status structs.
package bbrc_pkg;

  localparam int MAX_LEN    = 1024;             // leaves of the tree, power of two
  localparam int LOG_LEN    = $clog2(MAX_LEN);
  localparam int NODE_W     = LOG_LEN + 1;      // node index width
  localparam int TREE_NODES = 2 * MAX_LEN;
  localparam int LEVELS     = LOG_LEN + 1;      // root through leaf
  localparam int LVL_W      = $clog2(LEVELS);
  localparam int POS_W      = 11;
  localparam int VAL_W      = 13;
  localparam int BAL_W      = 12;
  localparam int LEN_RESET  = 1024;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t STEP_UP = 13'sd2;
  localparam val_t STEP_DN = -13'sd2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SET   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    W_LOAD   = 3'd0,
    W_SET    = 3'd1,
    W_BEFORE = 3'd2,
    W_ATR    = 3'd3,
    W_MIN    = 3'd4
  } walk_t;

  typedef struct packed {
    logic  clr_step;
    logic  latch;
    logic  load_commit;
    logic  brk_wr;
    logic  walk_start;
    walk_t walk;
    logic  eval_save;
    logic  cov_wr;
    logic  ret_min;
    logic  push_left;
    logic  push_right;
    logic  save_m;
    logic  fin_get;
    logic  pop;
    logic  kid_l;
    logic  kid_r;
    logic  fin_add;
    logic  capture;
    logic  zero_before;
    logic  zero_result;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    op_t  op;
    logic load_ok;
    logic set_ok;
    logic same_brk;
    logic query_ok;
    logic pos_one;
    logic is_add;
    logic disjoint;
    logic covered;
    logic need_left;
    logic need_right;
    logic ph;
    logic at_root;
  } sts_t;

  function automatic val_t val_min(val_t a, val_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== sv/bbrc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package dependency.
module bbrc_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bbrc_datapath.sv =====
// Datapath: length register, item latches, bracket store, tree memories and walk stack.
// Uses bbrc_pkg and bbrc_ram; driven by commands from bbrc_controller.
module bbrc_datapath
  import bbrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [1:0]       opcode,
  input  logic [POS_W-1:0] position,
  input  logic [POS_W-1:0] right_end,
  input  logic             is_open,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [POS_W-1:0] cfg_data,
  output logic             balanced
);

  logic [POS_W-1:0] str_len;
  logic [POS_W-1:0] n_eff;
  op_t              op_q;
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] rend_q;
  logic             open_q;
  logic [POS_W-1:0] load_count;
  logic signed [BAL_W-1:0] rb;
  logic [NODE_W-1:0] clr_cnt;

  logic [LOG_LEN-1:0] a0, b0;
  val_t               v;
  logic               is_add;
  logic [LVL_W-1:0]   k;
  logic [LVL_W-1:0]   k_up;

  logic [NODE_W-1:0]  node_s [LEVELS];
  logic [LOG_LEN-1:0] lo_s   [LEVELS];
  logic               ph_s   [LEVELS];
  logic               have_s [LEVELS];
  val_t               pend_s [LEVELS];
  val_t               m_s    [LEVELS];

  val_t ret, kid_l_val, pre_bal, at_r;

  logic [NODE_W-1:0]  cur_node, span, half, lo_ext, hi_ext, mid_ext;
  logic [LOG_LEN-1:0] cur_lo, hi, mid;
  logic [POS_W-1:0]   pos_m1, pos_m2, rend_m1, n_m1, lc_m1;

  logic               min_we, pend_we, brk_we, brk_wdata, brk_rd;
  logic [NODE_W-1:0]  min_waddr, min_raddr, pend_waddr;
  logic [VAL_W-1:0]   min_wdata, pend_wdata, min_rdv, pend_rdv;
  logic [LOG_LEN-1:0] brk_waddr;
  val_t               min_rd, pend_rd;

  assign n_eff   = (str_len > POS_W'(MAX_LEN)) ? POS_W'(MAX_LEN) : str_len;
  assign pos_m1  = pos_q - POS_W'(1);
  assign pos_m2  = pos_q - POS_W'(2);
  assign rend_m1 = rend_q - POS_W'(1);
  assign n_m1    = n_eff - POS_W'(1);
  assign lc_m1   = load_count - POS_W'(1);

  assign k_up     = k + LVL_W'(1);
  assign cur_node = node_s[k];
  assign cur_lo   = lo_s[k];
  assign span     = NODE_W'(MAX_LEN) >> k;
  assign half     = span >> 1;
  assign lo_ext   = {1'b0, cur_lo};
  assign hi_ext   = lo_ext + span - NODE_W'(1);
  assign mid_ext  = lo_ext + half - NODE_W'(1);
  assign hi       = hi_ext[LOG_LEN-1:0];
  assign mid      = mid_ext[LOG_LEN-1:0];

  assign min_rd  = val_t'(min_rdv);
  assign pend_rd = val_t'(pend_rdv);

  always_comb begin
    sts.clr_done   = &clr_cnt;
    sts.op         = op_q;
    sts.load_ok    = load_count < n_eff;
    sts.set_ok     = (pos_q != '0) && (pos_q <= n_eff);
    sts.same_brk   = brk_rd == open_q;
    sts.query_ok   = (pos_q != '0) && (rend_q >= pos_q) && (rend_q <= n_eff)
                     && (rend_q[0] != pos_q[0]);
    sts.pos_one    = pos_q == POS_W'(1);
    sts.is_add     = is_add;
    sts.disjoint   = (b0 < cur_lo) || (hi < a0);
    sts.covered    = (a0 <= cur_lo) && (hi <= b0);
    sts.need_left  = a0 <= mid;
    sts.need_right = b0 > mid;
    sts.ph         = ph_s[k];
    sts.at_root    = k == '0;
  end

  // tree memory ports
  always_comb begin
    min_we     = 1'b0;
    min_waddr  = cur_node;
    min_wdata  = '0;
    pend_we    = 1'b0;
    pend_waddr = cur_node;
    pend_wdata = '0;
    if (cmd.clr_step) begin
      min_we     = 1'b1;
      min_waddr  = clr_cnt;
      pend_we    = 1'b1;
      pend_waddr = clr_cnt;
    end else if (cmd.cov_wr) begin
      min_we     = 1'b1;
      min_wdata  = min_rd + v;
      pend_we    = 1'b1;
      pend_wdata = pend_rd + v;
    end else if (cmd.fin_add) begin
      min_we     = 1'b1;
      min_wdata  = val_min(kid_l_val, min_rd) + pend_s[k];
    end
    if (cmd.kid_l) begin
      min_raddr = cur_node + NODE_W'(1);
    end else if (cmd.kid_r) begin
      min_raddr = cur_node + span;
    end else begin
      min_raddr = cur_node;
    end
  end

  assign brk_we    = cmd.load_commit | cmd.brk_wr;
  assign brk_waddr = cmd.load_commit ? load_count[LOG_LEN-1:0] : pos_m1[LOG_LEN-1:0];
  assign brk_wdata = open_q;

  bbrc_ram #(.WIDTH(VAL_W), .DEPTH(TREE_NODES)) u_min_ram (
    .clk(clk), .we(min_we), .waddr(min_waddr), .wdata(min_wdata),
    .raddr(min_raddr), .rdata(min_rdv)
  );

  bbrc_ram #(.WIDTH(VAL_W), .DEPTH(TREE_NODES)) u_pend_ram (
    .clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
    .raddr(cur_node), .rdata(pend_rdv)
  );

  bbrc_ram #(.WIDTH(1), .DEPTH(MAX_LEN)) u_brk_ram (
    .clk(clk), .we(brk_we), .waddr(brk_waddr), .wdata(brk_wdata),
    .raddr(pos_m1[LOG_LEN-1:0]), .rdata(brk_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      str_len    <= POS_W'(LEN_RESET);
      load_count <= '0;
      rb         <= '0;
      clr_cnt    <= '0;
      k          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        str_len <= cfg_data;
      end
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + NODE_W'(1);
      end
      if (cmd.load_commit) begin
        load_count <= load_count + POS_W'(1);
        rb         <= rb + (open_q ? BAL_W'(1) : {BAL_W{1'b1}});
      end
      if (cmd.walk_start) begin
        k <= '0;
      end else if (cmd.push_left || cmd.push_right) begin
        k <= k_up;
      end else if (cmd.pop) begin
        k <= k - LVL_W'(1);
      end
    end
  end

  // payload and walk stack
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= op_t'(opcode);
      pos_q  <= position;
      rend_q <= right_end;
      open_q <= is_open;
    end
    if (cmd.walk_start) begin
      node_s[0] <= '0;
      lo_s[0]   <= '0;
      case (cmd.walk)
        W_LOAD: begin
          a0 <= lc_m1[LOG_LEN-1:0];
          b0 <= lc_m1[LOG_LEN-1:0];
          v  <= $signed({{(VAL_W-BAL_W){rb[BAL_W-1]}}, rb});
          is_add <= 1'b1;
        end
        W_SET: begin
          a0 <= pos_m1[LOG_LEN-1:0];
          b0 <= n_m1[LOG_LEN-1:0];
          v  <= open_q ? STEP_UP : STEP_DN;
          is_add <= 1'b1;
        end
        W_BEFORE: begin
          a0 <= pos_m2[LOG_LEN-1:0];
          b0 <= pos_m2[LOG_LEN-1:0];
          is_add <= 1'b0;
        end
        W_ATR: begin
          a0 <= rend_m1[LOG_LEN-1:0];
          b0 <= rend_m1[LOG_LEN-1:0];
          is_add <= 1'b0;
        end
        default: begin
          a0 <= pos_m1[LOG_LEN-1:0];
          b0 <= rend_m1[LOG_LEN-1:0];
          is_add <= 1'b0;
        end
      endcase
    end
    if (cmd.eval_save) begin
      pend_s[k] <= pend_rd;
      have_s[k] <= 1'b0;
    end
    if (cmd.ret_min) begin
      ret <= min_rd;
    end
    if (cmd.save_m) begin
      m_s[k]    <= ret;
      have_s[k] <= 1'b1;
    end
    if (cmd.push_left) begin
      ph_s[k]      <= 1'b0;
      node_s[k_up] <= cur_node + NODE_W'(1);
      lo_s[k_up]   <= cur_lo;
    end
    if (cmd.push_right) begin
      ph_s[k]      <= 1'b1;
      node_s[k_up] <= cur_node + span;
      lo_s[k_up]   <= cur_lo + half[LOG_LEN-1:0];
    end
    if (cmd.fin_get) begin
      ret <= ((ph_s[k] && have_s[k]) ? val_min(m_s[k], ret) : ret) + pend_s[k];
    end
    if (cmd.kid_r) begin
      kid_l_val <= min_rd;
    end
    if (cmd.zero_before) begin
      pre_bal <= '0;
    end
    if (cmd.zero_result) begin
      balanced <= 1'b0;
    end
    if (cmd.capture) begin
      case (cmd.walk)
        W_BEFORE: pre_bal <= ret;
        W_ATR:    at_r   <= ret;
        W_MIN:    balanced <= (pre_bal == at_r) && (ret >= at_r);
        default:  ;
      endcase
    end
  end

endmodule

// ===== sv/bbrc_controller.sv =====
// Controller: sequences clearing, item decode and the segment tree walks.
// Uses bbrc_pkg; issues cmd_t to bbrc_datapath and reads back sts_t.
module bbrc_controller
  import bbrc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic result_valid
);

  typedef enum logic [13:0] {
    S_CLEAR   = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_DECODE  = 14'b00000000000100,
    S_SET_RD  = 14'b00000000001000,
    S_SET_CHK = 14'b00000000010000,
    S_WSTART  = 14'b00000000100000,
    S_ENTER   = 14'b00000001000000,
    S_EVAL    = 14'b00000010000000,
    S_RETURN  = 14'b00000100000000,
    S_RESUME  = 14'b00001000000000,
    S_KID_L   = 14'b00010000000000,
    S_KID_R   = 14'b00100000000000,
    S_FIN_ADD = 14'b01000000000000,
    S_REPORT  = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  walk_t  walk, walk_next;

  assign busy         = state != S_IDLE;
  assign result_valid = state == S_REPORT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      walk  <= W_LOAD;
    end else begin
      state <= state_next;
      walk  <= walk_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.walk   = walk;
    state_next = state;
    walk_next  = walk;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          OP_LOAD: begin
            if (sts.load_ok) begin
              cmd.load_commit = 1'b1;
              walk_next       = W_LOAD;
              state_next      = S_WSTART;
            end else begin
              state_next = S_IDLE;
            end
          end
          OP_SET: state_next = sts.set_ok ? S_SET_RD : S_IDLE;
          OP_QUERY: begin
            if (!sts.query_ok) begin
              cmd.zero_result = 1'b1;
              state_next      = S_REPORT;
            end else if (sts.pos_one) begin
              cmd.zero_before = 1'b1;
              walk_next       = W_ATR;
              state_next      = S_WSTART;
            end else begin
              walk_next  = W_BEFORE;
              state_next = S_WSTART;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SET_RD: state_next = S_SET_CHK;
      S_SET_CHK: begin
        if (sts.same_brk) begin
          state_next = S_IDLE;
        end else begin
          cmd.brk_wr = 1'b1;
          walk_next  = W_SET;
          state_next = S_WSTART;
        end
      end
      S_WSTART: begin
        cmd.walk_start = 1'b1;
        state_next     = S_ENTER;
      end
      S_ENTER: state_next = S_EVAL;
      S_EVAL: begin
        cmd.eval_save = 1'b1;
        if (sts.is_add) begin
          if (sts.disjoint) begin
            state_next = S_RETURN;
          end else if (sts.covered) begin
            cmd.cov_wr = 1'b1;
            state_next = S_RETURN;
          end else begin
            cmd.push_left = 1'b1;
            state_next    = S_ENTER;
          end
        end else if (sts.covered) begin
          cmd.ret_min = 1'b1;
          state_next  = S_RETURN;
        end else begin
          // descend left when the range reaches into it, else right only
          cmd.push_left  = sts.need_left;
          cmd.push_right = !sts.need_left;
          state_next     = S_ENTER;
        end
      end
      S_RETURN: begin
        if (sts.at_root) begin
          cmd.capture = 1'b1;
          case (walk)
            W_BEFORE: begin
              walk_next  = W_ATR;
              state_next = S_WSTART;
            end
            W_ATR: begin
              walk_next  = W_MIN;
              state_next = S_WSTART;
            end
            W_MIN:   state_next = S_REPORT;
            default: state_next = S_IDLE;
          endcase
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_RESUME;
        end
      end
      S_RESUME: begin
        if (sts.is_add) begin
          if (!sts.ph) begin
            cmd.push_right = 1'b1;
            state_next     = S_ENTER;
          end else begin
            state_next = S_KID_L;
          end
        end else if (!sts.ph && sts.need_right) begin
          cmd.save_m     = 1'b1;
          cmd.push_right = 1'b1;
          state_next     = S_ENTER;
        end else begin
          cmd.fin_get = 1'b1;
          state_next  = S_RETURN;
        end
      end
      S_KID_L: begin
        cmd.kid_l  = 1'b1;
        state_next = S_KID_R;
      end
      S_KID_R: begin
        cmd.kid_r  = 1'b1;
        state_next = S_FIN_ADD;
      end
      S_FIN_ADD: begin
        cmd.fin_add = 1'b1;
        state_next  = S_RETURN;
      end
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_strobe_one: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("result strobe held");
  a_busy_after_rst: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> busy) else $error("idle right after reset");
  a_cov_wr: assert property (@(posedge clk) disable iff (rst)
    cmd.cov_wr |-> (sts.covered && sts.is_add)) else $error("bad covered write");
`endif

endmodule

// ===== sv/bracket_balance_range_checker_core.sv =====
// Work per item: one tree walk per load or set; a valid query takes three walks (two points,
// one range), or two (one point, one range) when it starts at position one, and an invalid
// query reports unbalanced with no walk. Busy stays high from the accept until the item is done,
// a query giving its result in its last busy cycle; ignored items also raise busy.
// Reset: busy stays high through a clearing pass over every node of the tree memories.
// One item at a time; result_valid strobes for one cycle and the receiver cannot stall.
module bracket_balance_range_checker_core
  import bbrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       opcode,
  input  logic [POS_W-1:0] position,
  input  logic [POS_W-1:0] right_end,
  input  logic             is_open,
  output logic             result_valid,
  output logic             balanced,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [POS_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bbrc_controller u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd),
    .busy(busy), .result_valid(result_valid)
  );

  bbrc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .opcode(opcode), .position(position), .right_end(right_end), .is_open(is_open),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .balanced(balanced)
  );

endmodule

// ===== verif/bracket_balance_range_checker_core_test.sv =====
// Self-checking testbench for bracket_balance_range_checker_core.
// Depends on bbrc_pkg; tracks prefix balances directly and checks each query answer.
`timescale 1ns / 100ps

module bracket_balance_range_checker_core_test;
  import bbrc_pkg::*;

  localparam int SETTLE = 300;   // longest walk sequence the block can still run
  localparam int LIM_CYC = 2_000_000;

  typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN} kind_t;

  typedef struct {
    kind_t            kind;
    op_t              op;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] rend;
    logic             open;
  } job_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       opcode = OP_NONE;
  logic [POS_W-1:0] position = '0;
  logic [POS_W-1:0] right_end = '0;
  logic             is_open = 1'b0;
  logic             result_valid;
  logic             balanced;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [POS_W-1:0] cfg_data = '0;

  bracket_balance_range_checker_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .position(position), .right_end(right_end), .is_open(is_open),
    .result_valid(result_valid), .balanced(balanced),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Prediction state: prefix balance per leaf, as the tree holds it
  int               leaf_bal [0:MAX_LEN];
  bit               brk_kind [1:MAX_LEN];
  int               run_bal;
  int               loaded;
  logic [POS_W-1:0] str_len;

  bit    balanced_due [$];
  job_t  pending [$];
  job_t  cur;
  int    gap;
  int    quiet;
  int    errors;

  // generation-time view of the string
  int    g_len;
  int    g_loads;
  int    g_bal;

  function automatic int eff_len(int v);
    return (v < MAX_LEN) ? v : MAX_LEN;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom % 100;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  task automatic predict_bracket_op(op_t op, int p, int r, bit o);
    int n;
    int pre_bal;
    int mn;
    bit ok;
    n = eff_len(str_len);
    case (op)
      OP_LOAD: begin
        if (loaded < n) begin
          loaded++;
          brk_kind[loaded] = o;
          run_bal += o ? 1 : -1;
          leaf_bal[loaded] += run_bal;
        end
      end
      OP_SET: begin
        if (p != 0 && p <= n && brk_kind[p] != o) begin
          brk_kind[p] = o;
          for (int k = p; k <= n; k++) leaf_bal[k] += o ? 2 : -2;
        end
      end
      OP_QUERY: begin
        ok = 0;
        if (p >= 1 && r >= p && r <= n && ((r - p + 1) % 2) == 0) begin
          pre_bal = (p == 1) ? 0 : leaf_bal[p-1];
          mn = leaf_bal[p];
          for (int k = p; k <= r; k++) if (leaf_bal[k] < mn) mn = leaf_bal[k];
          ok = (pre_bal == leaf_bal[r]) && (mn >= leaf_bal[r]);
        end
        balanced_due.push_back(ok);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Stimulus queue builders
  task automatic add_item(op_t op, int p, int r, bit o);
    job_t j;
    j.kind = K_ITEM; j.op = op; j.pos = POS_W'(p); j.rend = POS_W'(r); j.open = o;
    pending.push_back(j);
    if (op == OP_LOAD && g_loads < eff_len(g_len)) begin
      g_loads++;
      g_bal += o ? 1 : -1;
    end
  endtask

  task automatic add_cfg(int v);
    job_t j;
    j.kind = K_CFG; j.op = OP_NONE; j.pos = POS_W'(v); j.rend = '0; j.open = 0;
    pending.push_back(j);
    g_len = v;
  endtask

  task automatic add_drain();
    job_t j;
    j.kind = K_DRAIN; j.op = OP_NONE; j.pos = '0; j.rend = '0; j.open = 0;
    pending.push_back(j);
  endtask

  task automatic add_random(int count);
    int n, roll, p, r, hi, maxk;
    bit o;
    for (int i = 0; i < count; i++) begin
      n = eff_len(g_len);
      roll = $urandom % 100;
      o = 1'($urandom % 2);
      if (roll < 3) begin
        add_item(OP_NONE, $urandom % 2048, $urandom % 2048, o);
      end else if (roll < 32) begin
        // keep the string mostly well formed so balanced answers show up
        if (g_bal <= 0) o = ($urandom % 100) < 95;
        add_item(OP_LOAD, $urandom % 2048, $urandom % 2048, o);
      end else if (roll < 55) begin
        p = (g_loads > 0) ? $urandom_range(1, g_loads) : 0;
        if ($urandom % 100 < 8) p = ($urandom % 2) ? 0 : $urandom_range(n + 1, 2047);
        if (p > g_loads && p <= n) p = 0;   // never touch a bracket not yet loaded
        add_item(OP_SET, p, $urandom % 2048, o);
      end else begin
        if ($urandom % 100 < 80) begin
          hi = (g_loads > 2) ? g_loads : 2;
          if (hi > n) hi = n;
          p = $urandom_range(1, hi);
          maxk = (hi - p + 1) / 2;
          if (maxk == 0) r = p;
          else begin
            if ($urandom % 2 && maxk > 6) maxk = 6;
            r = p - 1 + 2 * $urandom_range(1, maxk);
          end
        end else begin
          p = $urandom % 2048;
          r = $urandom % 2048;
          if ($urandom % 2) begin p = p % 8; r = r % 16; end
        end
        add_item(OP_QUERY, p, r, o);
      end
    end
  endtask

  // Driver
  always @(posedge clk) begin : drive
    logic nx_start;
    logic nx_cfg;
    int   nx_quiet;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      gap <= 0;
      quiet <= 0;
    end else begin
      nx_start = start;
      nx_cfg = cfg_valid;
      if (start && !busy) begin
        predict_bracket_op(cur.op, cur.pos, cur.rend, cur.open);
        nx_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        str_len = cur.pos;
        nx_cfg = 1'b0;
      end
      nx_quiet = (balanced_due.size() == 0 && !busy && !nx_start && !nx_cfg) ? quiet + 1 : 0;
      if (!nx_start && !nx_cfg) begin
        if (gap > 0) begin
          gap <= gap - 1;
        end else if (pending.size() > 0) begin
          if (pending[0].kind == K_ITEM) begin
            cur = pending.pop_front();
            opcode <= cur.op;
            position <= cur.pos;
            right_end <= cur.rend;
            is_open <= cur.open;
            nx_start = 1'b1;
            gap <= pick_gap();
          end else if (quiet >= SETTLE) begin
            // hold register writes and drains until the block has settled
            cur = pending.pop_front();
            if (cur.kind == K_CFG) begin
              cfg_data <= cur.pos;
              nx_cfg = 1'b1;
            end
            nx_quiet = 0;
          end
        end
      end
      quiet <= nx_quiet;
      start <= nx_start;
      cfg_valid <= nx_cfg;
    end
  end

  // Monitor
  always @(posedge clk) begin : watch
    bit want;
    if (!rst && result_valid) begin
      if (balanced_due.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        want = balanced_due.pop_front();
        if (balanced !== want)
          report_mismatch($sformatf("balanced got %b want %b", balanced, want));
      end
    end
  end

  initial begin
    #(LIM_CYC * 20);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    errors = 0;
    run_bal = 0;
    loaded = 0;
    str_len = POS_W'(LEN_RESET);
    for (int k = 0; k <= MAX_LEN; k++) leaf_bal[k] = 0;
    g_len = LEN_RESET;
    g_loads = 0;
    g_bal = 0;

    // directed: empty tree, out-of-range shapes, a small nested string
    add_item(OP_QUERY, 1, 2, 1);
    add_item(OP_QUERY, 0, 2, 0);
    add_item(OP_QUERY, 3, 2, 1);
    add_item(OP_QUERY, 1, 2047, 0);
    add_item(OP_QUERY, 1, 1024, 1);
    add_item(OP_NONE, 2047, 2047, 1);
    add_item(OP_SET, 0, 0, 1);
    add_item(OP_SET, 2047, 0, 1);
    add_item(OP_LOAD, 0, 0, 1);
    add_item(OP_LOAD, 0, 0, 1);
    add_item(OP_LOAD, 0, 0, 0);
    add_item(OP_LOAD, 0, 0, 0);
    add_item(OP_LOAD, 0, 0, 1);
    add_item(OP_LOAD, 0, 0, 0);
    add_item(OP_QUERY, 1, 4, 0);
    add_item(OP_QUERY, 2, 3, 0);
    add_item(OP_QUERY, 1, 6, 0);
    add_item(OP_QUERY, 2, 5, 0);
    add_item(OP_QUERY, 1, 3, 0);
    add_item(OP_SET, 2, 0, 0);
    add_item(OP_QUERY, 1, 4, 0);
    add_item(OP_SET, 2, 0, 0);
    add_item(OP_SET, 2, 0, 1);
    add_item(OP_QUERY, 1, 1024, 0);

    // shortest string: loads are dropped, bounds clip
    add_cfg(1);
    add_item(OP_LOAD, 0, 0, 1);
    add_item(OP_QUERY, 1, 1, 0);
    add_item(OP_SET, 1, 0, 0);
    add_item(OP_QUERY, 1, 2, 0);
    add_random(30);

    add_cfg(2047);
    add_random(130);
    add_drain();
    add_random(60);
    add_cfg(40);
    add_random(130);
    add_cfg(LEN_RESET);
    add_random(120);
    add_cfg(300);
    add_random(130);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    wait (pending.size() == 0 && !start && !cfg_valid && balanced_due.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && balanced_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
